// ===== rtl/core/settling_window_detector_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the settling window detector
// Checks are clocked on clk and switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef SETTLING_WINDOW_DETECTOR_CORE_ASSERT_SVH
`define SETTLING_WINDOW_DETECTOR_CORE_ASSERT_SVH

// condition must hold at every edge
`define SWD_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// consequent must hold in the cycle after the antecedent
`define SWD_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/swd_pkg.sv =====
// ---------------------------------------------------------------------------
// swd_pkg
// Shared constants, types and helpers of the settling window detector.
// ---------------------------------------------------------------------------
package swd_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int MIN_READINGS = 3;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_WINDOW    = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  typedef enum logic [1:0] {
    VERDICT_WAIT    = 2'd0,
    VERDICT_STABLE  = 2'd1,
    VERDICT_INVALID = 2'd2,
    VERDICT_TIMEOUT = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_PRUNE,
    S_CHECK,
    S_DECIDE,
    S_OUT
  } state_t;

  // per-cell control: load takes the new reading, shift takes the neighbor's
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // |a - b| without overflow
  function automatic logic [32:0] abs_dev(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

endpackage

// ===== rtl/core/swd_cell.sv =====
// ---------------------------------------------------------------------------
// swd_cell
// One window slot: holds a reading's time and value and flags whether the
// value is within tolerance of the current target.
// ---------------------------------------------------------------------------
module swd_cell (
  input  logic               clk,
  input  swd_pkg::cell_ctl_t ctl,
  input  logic [31:0]        nbr_time,
  input  logic [31:0]        nbr_value,
  input  logic [31:0]        new_time,
  input  logic [31:0]        new_value,
  input  logic [31:0]        target_value,
  input  logic [30:0]        tolerance,
  output logic [31:0]        cell_time,
  output logic [31:0]        cell_value,
  output logic               in_tol
);
  import swd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cell_time  <= new_time;
      cell_value <= new_value;
    end else if (ctl.shift) begin
      cell_time  <= nbr_time;
      cell_value <= nbr_value;
    end
  end

  assign in_tol = abs_dev(cell_value, target_value) <= {2'b00, tolerance};

endmodule

// ===== rtl/core/settling_window_detector_core.sv =====
// ---------------------------------------------------------------------------
// settling_window_detector_core
// Judges whether timestamped readings have settled onto a setpoint.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): one reading per transaction,
//   start_of_wait clears window and verdict before the reading is handled.
//   Response channel (rsp_valid / rsp_stall): exactly one result per request.
//   Config channel (cfg_valid / cfg_ready): cfg_index picks target, tolerance,
//   window or timeout; write only while the block is idle. cfg_ready is
//   always high.
// Timing:
//   A reading that is stored walks through append, head pruning (one entry
//   per cycle), check and decide before its result is registered, with P
//   entries pruned, P being 0 to WINDOW_DEPTH-1. A reading that is not
//   stored (invalid, or a verdict already latched) goes from append
//   straight to the output state. The next request is taken only once
//   the block is back in idle, after the result is registered, so a new
//   request is not taken before the last one is through.
// Reset: window empty, verdict waiting, configuration registers at their defaults.
// Stall: a result held by rsp_stall stays put; the block keeps working on the
//   next request and waits only when its own result is ready to be loaded.
// ---------------------------------------------------------------------------
`include "settling_window_detector_core_assert.svh"

module settling_window_detector_core (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        start_of_wait,
  input  logic        reading_valid,
  input  logic [31:0] elapsed_ms,
  input  logic signed [31:0] reading_value,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  verdict,
  output logic [31:0] abs_error,
  output logic [5:0]  window_fill,
  output logic [31:0] window_span,
  output logic        dropped_oldest,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import swd_pkg::*;

  // configuration registers
  logic signed [31:0] target_value;
  logic [30:0]        tolerance;
  logic [31:0]        window_ms;
  logic [31:0]        timeout_ms;

  // control state
  state_t     state, state_next;
  verdict_t   final_verdict;
  logic [CNT_W-1:0] held_count;

  // latched request
  logic        req_start;
  logic        req_ok;
  logic [31:0] req_time;
  logic [31:0] req_value;

  // per-item scratch
  logic [31:0] res_err;
  logic [31:0] res_span;
  logic        res_dropped;
  logic        all_ok;

  // cell chain
  cell_ctl_t   cell_ctl   [WINDOW_DEPTH];
  logic [31:0] cell_time  [WINDOW_DEPTH];
  logic [31:0] cell_value [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] cell_ok;

  logic        req_take;
  logic        rsp_take;
  logic        out_load;
  logic        store_go;
  logic        full;
  logic        head_old;
  logic        prune_go;
  logic [32:0] head_diff;
  logic [32:0] item_dev;
  logic        all_ok_next;
  logic [35:0] span_x10;
  logic [35:0] window_x9;
  logic        stable;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_take  = rsp_valid && !rsp_stall;

  assign full      = (held_count == CNT_W'(WINDOW_DEPTH));
  assign item_dev  = abs_dev(req_value, target_value);

  // head entry against the newest time; a head newer than now is never old
  assign head_diff = {1'b0, req_time} - {1'b0, cell_time[0]};
  assign head_old  = !head_diff[32] && (head_diff[31:0] > window_ms);

  // 10*span >= 9*window with shifts and adds
  assign span_x10  = {res_span, 3'b000} + {3'b000, res_span, 1'b0};
  assign window_x9 = {window_ms, 3'b000} + {4'b0000, window_ms};
  assign stable    = (held_count >= CNT_W'(MIN_READINGS)) && all_ok
                     && (span_x10 >= window_x9);

  // tolerance test over occupied cells; empty slots pass
  always_comb begin
    all_ok_next = 1'b1;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (CNT_W'(i) < held_count && !cell_ok[i]) all_ok_next = 1'b0;
    end
  end

  // next state and cell controls
  always_comb begin
    state_next = state;
    store_go   = 1'b0;
    prune_go   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_take) state_next = S_APPEND;
      end
      S_APPEND: begin
        if (final_verdict != VERDICT_WAIT || !req_ok) begin
          state_next = S_OUT;
        end else begin
          store_go   = 1'b1;
          state_next = S_PRUNE;
        end
      end
      S_PRUNE: begin
        if (head_old) prune_go = 1'b1;
        else state_next = S_CHECK;
      end
      S_CHECK:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_OUT;
      S_OUT: begin
        if (!rsp_valid || !rsp_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // each cell shifts toward the head on a drop or a prune; the append lands
  // at the fill position, or in the last slot when the store is full
  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      cell_ctl[i].shift = prune_go || (store_go && full);
      cell_ctl[i].load  = store_go && (full ? (i == WINDOW_DEPTH - 1)
                                             : (CNT_W'(i) == held_count));
    end
  end

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      swd_cell u_cell (
        .clk          (clk),
        .ctl          (cell_ctl[g]),
        .nbr_time     (cell_time[(g + 1) % WINDOW_DEPTH]),
        .nbr_value    (cell_value[(g + 1) % WINDOW_DEPTH]),
        .new_time     (req_time),
        .new_value    (req_value),
        .target_value (target_value),
        .tolerance    (tolerance),
        .cell_time    (cell_time[g]),
        .cell_value   (cell_value[g]),
        .in_tol       (cell_ok[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= '0;
      tolerance    <= 31'd256;
      window_ms    <= 32'd10000;
      timeout_ms   <= 32'd60000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET:    target_value <= cfg_data;
        REG_TOLERANCE: tolerance    <= cfg_data[30:0];
        REG_WINDOW:    window_ms    <= cfg_data;
        REG_TIMEOUT:   timeout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // window count and latched verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      final_verdict <= VERDICT_WAIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_take && start_of_wait) begin
            held_count    <= '0;
            final_verdict <= VERDICT_WAIT;
          end
        end
        S_APPEND: begin
          if (final_verdict == VERDICT_WAIT && !req_ok) final_verdict <= VERDICT_INVALID;
          else if (store_go && !full) held_count <= held_count + 1'b1;
        end
        S_PRUNE: begin
          if (prune_go) held_count <= held_count - 1'b1;
        end
        S_DECIDE: begin
          if (stable) final_verdict <= VERDICT_STABLE;
          else if (req_time > timeout_ms) final_verdict <= VERDICT_TIMEOUT;
        end
        default: ;
      endcase
    end
  end

  // request latch and per-item results
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_start <= start_of_wait;
      req_ok    <= reading_valid;
      req_time  <= elapsed_ms;
      req_value <= reading_value;
    end
    if (state == S_APPEND) begin
      // an unreadable sample reports no error, latched verdict or not
      res_err     <= req_ok ? item_dev[31:0] : 32'd0;
      res_span    <= '0;
      res_dropped <= store_go && full;
    end
    if (state == S_CHECK) begin
      res_span <= head_diff[32] ? 32'd0 : head_diff[31:0];
      all_ok   <= all_ok_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_take) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict        <= final_verdict;
      abs_error      <= res_err;
      window_fill    <= 6'(held_count);
      window_span    <= res_span;
      dropped_oldest <= res_dropped;
    end
  end

  // checks
  `SWD_CHECK(a_count_bound, held_count <= CNT_W'(WINDOW_DEPTH))
  `SWD_CHECK(a_newest_kept, (state != S_CHECK) || (held_count != '0))
  `SWD_CHECK(a_take_when_idle, !req_take || (state == S_IDLE))
  `SWD_CHECK_NEXT(a_verdict_held, (state == S_APPEND) && (final_verdict != VERDICT_WAIT),
                  final_verdict == $past(final_verdict))
  `SWD_CHECK_NEXT(a_start_clears, req_take && start_of_wait,
                  (held_count == '0) && (final_verdict == VERDICT_WAIT) && req_start)

endmodule
